// ===== design/node_occupancy_tracker_core_assert.svh =====
`ifndef NODE_OCCUPANCY_TRACKER_CORE_ASSERT_SVH
`define NODE_OCCUPANCY_TRACKER_CORE_ASSERT_SVH

// Check that a condition implies a property in the same cycle.
`define NOTR_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies a property in the following cycle.
`define NOTR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/notr_pkg.sv =====
package notr_pkg;

    // Parameter defaults
    localparam int NODE_COUNT_DEF  = 1024;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TIME_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int AREA_W     = 48;
    localparam int NODE_W     = 10;
    localparam int CNT_IN_W   = 16;
    localparam int TIME_IN_W  = 32;
    localparam int MODE_W     = 2;
    localparam int OUT_CNT_W  = 16;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 176;

    // Mode bits: low bit selects lower, high bit selects the susceptible class
    localparam int MODE_LOWER_BIT = 0;
    localparam int MODE_SUS_BIT   = 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic mul_en;
        logic wr_en;
        logic clr;
        logic out_load;
    } ctrl_t;

endpackage

// ===== design/notr_ram.sv =====
module notr_ram
    import notr_pkg::*;
#(
    parameter int DEPTH  = NODE_COUNT_DEF,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(NODE_COUNT_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= entry_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/notr_ctrl.sv =====
module notr_ctrl
    import notr_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ADDR_W     = $clog2(NODE_COUNT_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              out_free,
    input  logic              in_range,
    output logic              s_tready,
    output ctrl_t             ctrl,
    output logic [ADDR_W-1:0] clr_addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;

    // State and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Sequence: sweep, wait, multiply, write back
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        s_tready      = 1'b0;
        ctrl          = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clr     = 1'b1;
                ctrl.wr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctrl.rd_en = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    ctrl.wr_en    = in_range;
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign clr_addr = clr_cnt_reg;

endmodule

// ===== design/notr_datapath.sv =====
module notr_datapath
    import notr_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int ENTRY_W     = 3 * AREA_W + 3 * TIME_WIDTH_DEF + 6 * COUNT_WIDTH_DEF
)
(
    input  logic                  clk,
    input  ctrl_t                 ctrl,
    input  logic [MODE_W-1:0]     mode,
    input  logic [NODE_W-1:0]     node,
    input  logic [CNT_IN_W-1:0]   total_count,
    input  logic [CNT_IN_W-1:0]   class_count,
    input  logic [TIME_IN_W-1:0]  time_now,
    input  logic [ENTRY_W-1:0]    rdata,
    output logic [ENTRY_W-1:0]    wdata,
    output logic                  in_range,
    output logic [OUT_DATA_W-1:0] result
);

    localparam int LO_W  = (TIME_WIDTH + 1) / 2;
    localparam int HI_W  = TIME_WIDTH - LO_W;
    localparam int PL_W  = LO_W + COUNT_WIDTH;
    localparam int PH_W  = HI_W + COUNT_WIDTH;
    localparam int SUM_W = TIME_WIDTH + COUNT_WIDTH + 1;
    localparam int EXT_W = (SUM_W > AREA_W + 1) ? SUM_W : AREA_W + 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [AREA_W-1:0]      AREA_MAX = '1;

    typedef struct packed {
        logic [AREA_W-1:0]      area_all;
        logic [AREA_W-1:0]      area_inf;
        logic [AREA_W-1:0]      area_sus;
        logic [TIME_WIDTH-1:0]  stamp_all;
        logic [TIME_WIDTH-1:0]  stamp_inf;
        logic [TIME_WIDTH-1:0]  stamp_sus;
        logic [COUNT_WIDTH-1:0] peak_all;
        logic [COUNT_WIDTH-1:0] peak_inf;
        logic [COUNT_WIDTH-1:0] peak_sus;
        logic [COUNT_WIDTH-1:0] floor_all;
        logic [COUNT_WIDTH-1:0] floor_inf;
        logic [COUNT_WIDTH-1:0] floor_sus;
    } entry_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [CNT_IN_W-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        if (32'(v) > 32'(CNT_MAX))
        begin
            r = CNT_MAX;
        end
        else
        begin
            r = COUNT_WIDTH'(v);
        end
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] prev_cnt(input logic [COUNT_WIDTH-1:0] c,
                                                        input logic lower);
        logic [COUNT_WIDTH-1:0] r;
        if (lower)
        begin
            r = (c == CNT_MAX) ? c : c + COUNT_WIDTH'(1);
        end
        else
        begin
            r = (c == '0) ? c : c - COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    // Combine partial products, clamp the product, then clamp the running sum
    function automatic logic [AREA_W-1:0] accum(input logic [AREA_W-1:0] area,
                                                input logic [PH_W-1:0] pp_hi,
                                                input logic [PL_W-1:0] pp_lo);
        logic [EXT_W-1:0]  prod;
        logic [AREA_W-1:0] p48;
        logic [AREA_W:0]   sum;
        prod = (EXT_W'(pp_hi) << LO_W) + EXT_W'(pp_lo);
        p48  = (prod > EXT_W'(AREA_MAX)) ? AREA_MAX : prod[AREA_W-1:0];
        sum  = {1'b0, area} + {1'b0, p48};
        return sum[AREA_W] ? AREA_MAX : sum[AREA_W-1:0];
    endfunction

    entry_t                 cur;
    entry_t                 upd;
    entry_t                 rst_entry;
    logic                   lower;
    logic                   sus;
    logic [TIME_WIDTH-1:0]  now;
    logic [COUNT_WIDTH-1:0] cnt_t;
    logic [COUNT_WIDTH-1:0] cnt_c;
    logic [COUNT_WIDTH-1:0] prev_t;
    logic [COUNT_WIDTH-1:0] prev_c;
    logic [TIME_WIDTH-1:0]  stamp_c;
    logic [AREA_W-1:0]      area_c;
    logic [COUNT_WIDTH-1:0] peak_c;
    logic [COUNT_WIDTH-1:0] floor_c;
    logic [TIME_WIDTH-1:0]  el_t;
    logic [TIME_WIDTH-1:0]  el_c;
    logic [PL_W-1:0]        pp_t_lo_reg;
    logic [PH_W-1:0]        pp_t_hi_reg;
    logic [PL_W-1:0]        pp_c_lo_reg;
    logic [PH_W-1:0]        pp_c_hi_reg;
    logic [AREA_W-1:0]      new_area_t;
    logic [AREA_W-1:0]      new_area_c;
    logic [COUNT_WIDTH-1:0] new_peak_t;
    logic [COUNT_WIDTH-1:0] new_peak_c;
    logic [COUNT_WIDTH-1:0] new_floor_t;
    logic [COUNT_WIDTH-1:0] new_floor_c;

    // Decode the event and select the class entries
    always_comb
    begin
        cur      = entry_t'(rdata);
        lower    = mode[MODE_LOWER_BIT];
        sus      = mode[MODE_SUS_BIT];
        now      = TIME_WIDTH'(time_now);
        cnt_t    = sat_cnt(total_count);
        cnt_c    = sat_cnt(class_count);
        prev_t   = prev_cnt(cnt_t, lower);
        prev_c   = prev_cnt(cnt_c, lower);
        stamp_c  = sus ? cur.stamp_sus : cur.stamp_inf;
        area_c   = sus ? cur.area_sus : cur.area_inf;
        peak_c   = sus ? cur.peak_sus : cur.peak_inf;
        floor_c  = sus ? cur.floor_sus : cur.floor_inf;
        el_t     = (now >= cur.stamp_all) ? now - cur.stamp_all : '0;
        el_c     = (now >= stamp_c) ? now - stamp_c : '0;
        in_range = 32'(node) < 32'(NODE_COUNT);
    end

    // Multiply elapsed time by the previous count in two halves
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            pp_t_lo_reg <= PL_W'(el_t[LO_W-1:0]) * PL_W'(prev_t);
            pp_t_hi_reg <= PH_W'(el_t[TIME_WIDTH-1:LO_W]) * PH_W'(prev_t);
            pp_c_lo_reg <= PL_W'(el_c[LO_W-1:0]) * PL_W'(prev_c);
            pp_c_hi_reg <= PH_W'(el_c[TIME_WIDTH-1:LO_W]) * PH_W'(prev_c);
        end
    end

    // Build the updated entry and the result word
    always_comb
    begin
        new_area_t  = accum(cur.area_all, pp_t_hi_reg, pp_t_lo_reg);
        new_area_c  = accum(area_c, pp_c_hi_reg, pp_c_lo_reg);
        new_peak_t  = (!lower && cnt_t > cur.peak_all) ? cnt_t : cur.peak_all;
        new_peak_c  = (!lower && cnt_c > peak_c) ? cnt_c : peak_c;
        new_floor_t = (lower && cnt_t < cur.floor_all) ? cnt_t : cur.floor_all;
        new_floor_c = (lower && cnt_c < floor_c) ? cnt_c : floor_c;

        upd           = cur;
        upd.area_all  = new_area_t;
        upd.stamp_all = now;
        upd.peak_all  = new_peak_t;
        upd.floor_all = new_floor_t;
        if (sus)
        begin
            upd.area_sus  = new_area_c;
            upd.stamp_sus = now;
            upd.peak_sus  = new_peak_c;
            upd.floor_sus = new_floor_c;
        end
        else
        begin
            upd.area_inf  = new_area_c;
            upd.stamp_inf = now;
            upd.peak_inf  = new_peak_c;
            upd.floor_inf = new_floor_c;
        end

        rst_entry           = '0;
        rst_entry.floor_all = CNT_MAX;
        rst_entry.floor_inf = CNT_MAX;
        rst_entry.floor_sus = CNT_MAX;

        wdata = ctrl.clr ? ENTRY_W'(rst_entry) : ENTRY_W'(upd);

        if (in_range)
        begin
            result = {6'b0,
                      OUT_CNT_W'(new_floor_c), OUT_CNT_W'(new_floor_t),
                      OUT_CNT_W'(new_peak_c), OUT_CNT_W'(new_peak_t),
                      new_area_c, new_area_t, node};
        end
        else
        begin
            result = {(OUT_DATA_W - NODE_W)'(0), node};
        end
    end

endmodule

// ===== design/node_occupancy_tracker_core.sv =====
// Time-weighted occupancy tracker, one state-memory entry per node.
// A result word passes the registered state-memory read, the partial-product
// registers and the output register; it waits in the add step while the output
// register holds a word not yet taken. Only one word is in flight: the read,
// multiply and write back share the single port of the state memory. Reset: rst_n
// clears control at once; a clearing pass then writes every memory entry while s_tready stays low.
`include "node_occupancy_tracker_core_assert.svh"

module node_occupancy_tracker_core
    import notr_pkg::*;
#(
    parameter int NODE_COUNT  = NODE_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // node[9:0], total_count[25:10], class_count[41:26], time_now[73:42], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // node_out[9:0], area_total[57:10], area_class[105:58], peak_total[121:106],
    // peak_class[137:122], floor_total[153:138], floor_class[169:154], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int ADDR_W  = $clog2(NODE_COUNT);
    localparam int ENTRY_W = 3 * AREA_W + 3 * TIME_WIDTH + 6 * COUNT_WIDTH;

    ctrl_t                 ctrl;
    logic [ADDR_W-1:0]     clr_addr;
    logic [ADDR_W-1:0]     ram_addr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  in_range;
    logic                  out_free;
    logic [OUT_DATA_W-1:0] result;

    logic [MODE_W-1:0]     mode_reg;
    logic [NODE_W-1:0]     node_reg;
    logic [CNT_IN_W-1:0]   total_reg;
    logic [CNT_IN_W-1:0]   class_reg;
    logic [TIME_IN_W-1:0]  time_reg;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Hold the accepted word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mode_reg  <= s_tuser;
            node_reg  <= s_tdata[9:0];
            total_reg <= s_tdata[25:10];
            class_reg <= s_tdata[41:26];
            time_reg  <= s_tdata[73:42];
        end
    end

    // Address: sweep counter, incoming node on read, held node on write back
    always_comb
    begin
        if (ctrl.clr)
        begin
            ram_addr = clr_addr;
        end
        else if (ctrl.rd_en)
        begin
            ram_addr = ADDR_W'(s_tdata[9:0]);
        end
        else
        begin
            ram_addr = ADDR_W'(node_reg);
        end
    end

    notr_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .in_range (in_range),
        .s_tready (s_tready),
        .ctrl     (ctrl),
        .clr_addr (clr_addr)
    );

    notr_ram #(
        .DEPTH  (NODE_COUNT),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .re    (ctrl.rd_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    notr_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIME_WIDTH  (TIME_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_datapath (
        .clk         (clk),
        .ctrl        (ctrl),
        .mode        (mode_reg),
        .node        (node_reg),
        .total_count (total_reg),
        .class_count (class_reg),
        .time_now    (time_reg),
        .rdata       (ram_rdata),
        .wdata       (ram_wdata),
        .in_range    (in_range),
        .result      (result)
    );

    // Output register: load a finished word, drop it once taken
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (ctrl.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `NOTR_ASSERT_SAME(a_no_accept_in_clear, s_tready, !ctrl.clr, "word accepted during clear")
    `NOTR_ASSERT_SAME(a_no_write_on_accept, ctrl.wr_en, !(s_tvalid && s_tready), "write on accept")
    `NOTR_ASSERT_SAME(a_out_slot_free, ctrl.out_load, !m_tvalid_reg || m_tready, "result overrun")
    `NOTR_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word in flight")

endmodule

// ===== test/node_occupancy_tracker_core_test.sv =====
`timescale 1ns / 100ps

module node_occupancy_tracker_core_test;
    import notr_pkg::*;

    localparam int NODES        = 1024;
    localparam int RANDOM_ITEMS = 1030;
    localparam int HOT_N        = 16;
    localparam int BACKLOG_AT   = 400;
    localparam int BACKLOG_LEN  = 500;
    localparam int SETTLE       = 20;
    localparam logic [63:0] AREA_SAT = 64'h0000_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        INF_RAISE = 2'd0,
        INF_LOWER = 2'd1,
        SUS_RAISE = 2'd2,
        SUS_LOWER = 2'd3
    } occ_mode_t;

    typedef struct {
        occ_mode_t   mode;
        logic [9:0]  node;
        logic [15:0] total_cnt;
        logic [15:0] class_cnt;
        logic [31:0] now_ticks;
        int unsigned gap;
        bit          drain;
    } occ_event_t;

    typedef struct {
        logic [9:0]  node;
        logic [47:0] area_total;
        logic [47:0] area_class;
        logic [15:0] peak_total;
        logic [15:0] peak_class;
        logic [15:0] floor_total;
        logic [15:0] floor_class;
    } occ_figures_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Per-node occupancy mirror
    logic [47:0] area_all_m   [NODES];
    logic [47:0] area_inf_m   [NODES];
    logic [47:0] area_sus_m   [NODES];
    logic [31:0] stamp_all_m  [NODES];
    logic [31:0] stamp_inf_m  [NODES];
    logic [31:0] stamp_sus_m  [NODES];
    logic [15:0] peak_all_m   [NODES];
    logic [15:0] peak_inf_m   [NODES];
    logic [15:0] peak_sus_m   [NODES];
    logic [15:0] floor_all_m  [NODES];
    logic [15:0] floor_inf_m  [NODES];
    logic [15:0] floor_sus_m  [NODES];

    occ_event_t   event_queue [$];
    occ_figures_t expected_figures [$];
    occ_event_t   offered_event;

    logic        word_taken   = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned words_in     = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned quiet_left   = 0;
    bit          hold_armed   = 1'b0;

    node_occupancy_tracker_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Add elapsed time times count to an area, saturating at 48 bits
    function automatic logic [47:0] time_weighted_add(logic [47:0] area, logic [31:0] stamp,
                                                      logic [31:0] now, logic [15:0] count);
        logic [63:0] elapsed;
        logic [63:0] prod;
        logic [63:0] sum;
        elapsed = (now >= stamp) ? ({32'd0, now} - {32'd0, stamp}) : 64'd0;
        prod = elapsed * {48'd0, count};
        if (prod > AREA_SAT)
            prod = AREA_SAT;
        sum = {16'd0, area} + prod;
        if (sum > AREA_SAT)
            sum = AREA_SAT;
        return sum[47:0];
    endfunction

    // Apply one event to the mirror and return the node's new figures
    function automatic occ_figures_t occupancy_update(occ_event_t ev);
        occ_figures_t f;
        logic         lower;
        logic         sus;
        logic [15:0]  prev_tot;
        logic [15:0]  prev_cls;
        logic [47:0]  a_cls;
        logic [31:0]  s_cls;
        logic [15:0]  pk_cls;
        logic [15:0]  fl_cls;
        int           n;
        n     = ev.node;
        lower = ev.mode[MODE_LOWER_BIT];
        sus   = ev.mode[MODE_SUS_BIT];
        if (lower)
        begin
            prev_tot = (ev.total_cnt != 16'hFFFF) ? ev.total_cnt + 16'd1 : ev.total_cnt;
            prev_cls = (ev.class_cnt != 16'hFFFF) ? ev.class_cnt + 16'd1 : ev.class_cnt;
        end
        else
        begin
            prev_tot = (ev.total_cnt != 16'd0) ? ev.total_cnt - 16'd1 : 16'd0;
            prev_cls = (ev.class_cnt != 16'd0) ? ev.class_cnt - 16'd1 : 16'd0;
        end
        a_cls  = sus ? area_sus_m[n]  : area_inf_m[n];
        s_cls  = sus ? stamp_sus_m[n] : stamp_inf_m[n];
        pk_cls = sus ? peak_sus_m[n]  : peak_inf_m[n];
        fl_cls = sus ? floor_sus_m[n] : floor_inf_m[n];

        area_all_m[n]  = time_weighted_add(area_all_m[n], stamp_all_m[n], ev.now_ticks, prev_tot);
        stamp_all_m[n] = ev.now_ticks;
        a_cls = time_weighted_add(a_cls, s_cls, ev.now_ticks, prev_cls);
        s_cls = ev.now_ticks;

        if (lower)
        begin
            if (ev.total_cnt < floor_all_m[n])
                floor_all_m[n] = ev.total_cnt;
            if (ev.class_cnt < fl_cls)
                fl_cls = ev.class_cnt;
        end
        else
        begin
            if (ev.total_cnt > peak_all_m[n])
                peak_all_m[n] = ev.total_cnt;
            if (ev.class_cnt > pk_cls)
                pk_cls = ev.class_cnt;
        end

        if (sus)
        begin
            area_sus_m[n]  = a_cls;
            stamp_sus_m[n] = s_cls;
            peak_sus_m[n]  = pk_cls;
            floor_sus_m[n] = fl_cls;
        end
        else
        begin
            area_inf_m[n]  = a_cls;
            stamp_inf_m[n] = s_cls;
            peak_inf_m[n]  = pk_cls;
            floor_inf_m[n] = fl_cls;
        end

        f.node        = ev.node;
        f.area_total  = area_all_m[n];
        f.area_class  = a_cls;
        f.peak_total  = peak_all_m[n];
        f.peak_class  = pk_cls;
        f.floor_total = floor_all_m[n];
        f.floor_class = fl_cls;
        return f;
    endfunction

    task automatic add_event(occ_mode_t mode, logic [9:0] node, logic [15:0] total_cnt,
                             logic [15:0] class_cnt, logic [31:0] now_ticks,
                             int unsigned gap, bit drain);
        occ_event_t ev;
        ev.mode      = mode;
        ev.node      = node;
        ev.total_cnt = total_cnt;
        ev.class_cnt = class_cnt;
        ev.now_ticks = now_ticks;
        ev.gap       = gap;
        ev.drain     = drain;
        event_queue.push_back(ev);
    endtask

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Random events: mostly consistent count walks on a few busy nodes, plus noise
    task automatic build_random_events();
        int          hot_id  [HOT_N];
        int          inf_cnt [HOT_N];
        int          sus_cnt [HOT_N];
        logic [31:0] clock_now;
        logic [31:0] stamp;
        occ_mode_t   mode;
        int          slot;
        int          cls;
        int unsigned gap;
        bit          calm;
        for (int i = 0; i < HOT_N; i++)
        begin
            hot_id[i]  = (i * 65) % NODES;
            inf_cnt[i] = 0;
            sus_cnt[i] = 0;
        end
        clock_now = 32'd200;
        calm = 1'b0;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : pick_gap();
            mode = occ_mode_t'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 80)
            begin
                // advance time, with an occasional jump or step back
                case ($urandom_range(0, 99)) inside
                    [0:4]:   clock_now = clock_now + $urandom_range(0, 1 << 20);
                    default: clock_now = clock_now + $urandom_range(0, 20);
                endcase
                stamp = clock_now;
                if ($urandom_range(0, 99) < 3)
                    stamp = (clock_now > 1000) ? clock_now - $urandom_range(1, 1000) : 32'd0;
                slot = $urandom_range(0, HOT_N - 1);
                if (mode == INF_LOWER && inf_cnt[slot] == 0)
                    mode = INF_RAISE;
                if (mode == SUS_LOWER && sus_cnt[slot] == 0)
                    mode = SUS_RAISE;
                case (mode)
                    INF_RAISE: inf_cnt[slot]++;
                    INF_LOWER: inf_cnt[slot]--;
                    SUS_RAISE: sus_cnt[slot]++;
                    default:   sus_cnt[slot]--;
                endcase
                cls = mode[MODE_SUS_BIT] ? sus_cnt[slot] : inf_cnt[slot];
                add_event(mode, 10'(hot_id[slot]), 16'(inf_cnt[slot] + sus_cnt[slot]), 16'(cls),
                          stamp, gap, (k == RANDOM_ITEMS / 2));
            end
            else
            begin
                add_event(mode,
                          ($urandom_range(0, 4) == 0) ? 10'(hot_id[$urandom_range(0, HOT_N - 1)])
                                                      : 10'($urandom_range(0, NODES - 1)),
                          16'($urandom), 16'($urandom), $urandom, gap, 1'b0);
            end
        end
    endtask

    // Driver: offer the next event once the current one is taken and its gap is spent
    always @(negedge clk)
    begin : event_driver
        logic nxt_valid;
        nxt_valid = s_tvalid;
        if (!rst_n)
            nxt_valid = 1'b0;
        else if (!s_tvalid || word_taken)
        begin
            nxt_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (event_queue.size() != 0 &&
                     !(event_queue[0].drain && expected_figures.size() != 0))
            begin
                offered_event = event_queue.pop_front();
                gap_left  = offered_event.gap;
                nxt_valid = 1'b1;
                s_tdata <= {6'd0, offered_event.now_ticks, offered_event.class_cnt,
                            offered_event.total_cnt, offered_event.node};
                s_tuser <= offered_event.mode;
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Receiver pacing: one long backlog, random stalls, quiet stretches
    always @(negedge clk)
    begin : sink_pace
        logic rdy;
        rdy = 1'b1;
        if (!rst_n)
            rdy = 1'b0;
        else
        begin
            if (!hold_armed && words_in >= BACKLOG_AT)
            begin
                hold_armed = 1'b1;
                hold_left  = BACKLOG_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (quiet_left > 0)
                quiet_left--;
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
                if (stall_left == 0 && $urandom_range(0, 9) == 0)
                    quiet_left = $urandom_range(50, 150);
            end
            else if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
        m_tready <= rdy;
    end

    // Monitor: check each result against the oldest expectation, then predict new inputs
    always @(posedge clk)
    begin : result_monitor
        occ_figures_t seen;
        occ_figures_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.node        = m_tdata[9:0];
                seen.area_total  = m_tdata[57:10];
                seen.area_class  = m_tdata[105:58];
                seen.peak_total  = m_tdata[121:106];
                seen.peak_class  = m_tdata[137:122];
                seen.floor_total = m_tdata[153:138];
                seen.floor_class = m_tdata[169:154];
                results_seen++;
                if (expected_figures.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_figures.pop_front();
                    check_field("node_out", 48'(want.node), 48'(seen.node));
                    check_field("area_total", want.area_total, seen.area_total);
                    check_field("area_class", want.area_class, seen.area_class);
                    check_field("peak_total", 48'(want.peak_total), 48'(seen.peak_total));
                    check_field("peak_class", 48'(want.peak_class), 48'(seen.peak_class));
                    check_field("floor_total", 48'(want.floor_total), 48'(seen.floor_total));
                    check_field("floor_class", 48'(want.floor_class), 48'(seen.floor_class));
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_figures.push_back(occupancy_update(offered_event));
                words_in++;
            end
            word_taken <= s_tvalid && s_tready;
        end
    end

    initial
    begin : run_control
        for (int i = 0; i < NODES; i++)
        begin
            area_all_m[i]  = '0;
            area_inf_m[i]  = '0;
            area_sus_m[i]  = '0;
            stamp_all_m[i] = '0;
            stamp_inf_m[i] = '0;
            stamp_sus_m[i] = '0;
            peak_all_m[i]  = '0;
            peak_inf_m[i]  = '0;
            peak_sus_m[i]  = '0;
            floor_all_m[i] = '1;
            floor_inf_m[i] = '1;
            floor_sus_m[i] = '1;
        end

        // raise from zero, lower from the maximum, time going backwards, area saturation
        add_event(INF_RAISE, 10'd0,    16'h0000, 16'h0000, 32'h0000_0000, 0, 1'b0);
        add_event(INF_LOWER, 10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_event(SUS_LOWER, 10'd1023, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 0, 1'b0);
        add_event(INF_LOWER, 10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_event(SUS_RAISE, 10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_event(SUS_LOWER, 10'd1023, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 0, 1'b0);
        add_event(SUS_LOWER, 10'd1023, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_event(INF_RAISE, 10'd1023, 16'h0000, 16'h0000, 32'h0000_000A, 0, 1'b0);
        add_event(SUS_RAISE, 10'd0,    16'h0000, 16'h0000, 32'h0000_0005, 0, 1'b0);
        add_event(INF_LOWER, 10'd0,    16'h0000, 16'h0000, 32'h0000_0005, 0, 1'b0);
        add_event(SUS_LOWER, 10'd0,    16'h0001, 16'h0001, 32'h0000_0009, 0, 1'b0);
        // alternating bit patterns on every field
        add_event(INF_RAISE, 10'h155,  16'h5555, 16'hAAAA, 32'h5555_5555, 0, 1'b0);
        add_event(INF_LOWER, 10'h155,  16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 0, 1'b0);
        add_event(SUS_RAISE, 10'h2AA,  16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 0, 1'b0);
        add_event(SUS_LOWER, 10'h2AA,  16'h5555, 16'hAAAA, 32'hFFFF_FFFF, 0, 1'b0);
        // back-to-back updates of one node
        add_event(INF_RAISE, 10'd512,  16'd1, 16'd1, 32'd100, 0, 1'b0);
        add_event(INF_RAISE, 10'd512,  16'd2, 16'd2, 32'd101, 0, 1'b0);
        add_event(SUS_RAISE, 10'd512,  16'd3, 16'd1, 32'd102, 0, 1'b0);
        add_event(INF_LOWER, 10'd512,  16'd2, 16'd1, 32'd102, 0, 1'b0);
        add_event(SUS_LOWER, 10'd512,  16'd1, 16'd0, 32'd150, 0, 1'b0);
        build_random_events();
        // hold the first random event until the directed results are all back
        event_queue[20].drain = 1'b1;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (event_queue.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_figures.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Ran %0d occupancy events over all four modes and %0d results,", words_in,
                 results_seen);
        $display("with saturating areas, time steps back and a %0d-cycle output backlog.",
                 BACKLOG_LEN);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("Timeout with %0d results outstanding", expected_figures.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
